>>> rtl/bps_pkg.sv
// Package for the box plot summary engine.
// Holds sizes, codes and shared types; depends on nothing.
package bps_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int IDX_W       = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int VAL_W       = 32;
  localparam int SUM_W       = VAL_W + IDX_W;
  localparam int WSK_W       = VAL_W + 4;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_CALC = 3'b100
  } state_e;

  // Shared control for the cell row.
  typedef struct packed {
    logic insert;
    logic rotate;
  } cell_ctrl_t;

endpackage

>>> rtl/bps_cell.sv
// One cell of the sorted row: holds one value and its arrival position.
// Depends on bps_pkg.
module bps_cell (
  input  logic                         clk_i,
  input  logic [bps_pkg::IDX_W-1:0]    cell_idx_i,
  input  logic [bps_pkg::CNT_W-1:0]    cnt_i,
  input  bps_pkg::cell_ctrl_t          ctrl_i,
  input  logic signed [bps_pkg::VAL_W-1:0] new_val_i,
  input  logic [bps_pkg::IDX_W-1:0]    new_pos_i,
  input  logic signed [bps_pkg::VAL_W-1:0] left_val_i,
  input  logic [bps_pkg::IDX_W-1:0]    left_pos_i,
  input  logic                         left_gt_i,
  input  logic signed [bps_pkg::VAL_W-1:0] right_val_i,
  input  logic [bps_pkg::IDX_W-1:0]    right_pos_i,
  output logic signed [bps_pkg::VAL_W-1:0] val_o,
  output logic [bps_pkg::IDX_W-1:0]    pos_o,
  output logic                         gt_o
);
  import bps_pkg::*;

  logic signed [VAL_W-1:0] val_q;
  logic [IDX_W-1:0]        pos_q;

  // An empty cell counts as holding plus infinity; the strict compare keeps equal values in order.
  assign gt_o  = ({1'b0, cell_idx_i} >= cnt_i) || (val_q > new_val_i);
  assign val_o = val_q;
  assign pos_o = pos_q;

  // Insertion shifts the larger entries one place up; rotation moves down.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.insert && gt_o) begin
      if (left_gt_i) begin
        val_q <= left_val_i;
        pos_q <= left_pos_i;
      end else begin
        val_q <= new_val_i;
        pos_q <= new_pos_i;
      end
    end else if (ctrl_i.rotate) begin
      val_q <= right_val_i;
      pos_q <= right_pos_i;
    end
  end

endmodule

>>> rtl/bps_div.sv
// Bit-serial signed divider for the mean, one quotient bit per cycle.
// Depends on bps_pkg.
module bps_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [bps_pkg::SUM_W-1:0] dividend_i,
  input  logic [bps_pkg::CNT_W-1:0]     divisor_i,
  output logic signed [bps_pkg::VAL_W-1:0] mean_o
);
  import bps_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [STEP_W-1:0] step_q;
  logic              neg_q;
  logic [SUM_W-1:0]  dvd_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  dsr_q;
  logic [CNT_W:0]    rem_sh;
  logic              qbit;

  // Restoring step on the magnitude.
  always_comb begin
    rem_sh = {rem_q, dvd_q[SUM_W-1]};
    qbit   = (rem_sh >= {1'b0, dsr_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (start_i) begin
      step_q <= STEP_W'(SUM_W);
    end else if (step_q != '0) begin
      step_q <= step_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SUM_W-1];
      dvd_q <= dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (step_q != '0) begin
      dvd_q <= {dvd_q[SUM_W-2:0], qbit};
      rem_q <= qbit ? CNT_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[CNT_W-1:0];
    end
  end

  // Truncation toward zero: sign restored on the magnitude quotient.
  assign mean_o = neg_q ? -$signed(dvd_q[VAL_W-1:0]) : $signed(dvd_q[VAL_W-1:0]);

endmodule

>>> rtl/box_plot_summary_engine_top.sv
// Top level of the box plot summary engine: cell row, scan and result logic.
// Depends on bps_pkg, bps_cell and bps_div.
//
//  Channel  | Direction | Contents
//  s_axis   | in        | tdata: sample_value, include_req; tuser: kind; tlast: last
//  m_axis   | out       | tdata: summary and query fields; tuser: result_kind
//  cfg      | in        | hinge_mode write, one bit
//
// A load without last leaves the engine idle; the sorted row inserts in place.
// A summary or query rotates the whole row once, past the single read point
// at cell 0.
// Reset clears counts and flags; the row contents are not cleared.
// A waiting result stalls the next finished result and, while that waits, all input.
module box_plot_summary_engine_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // sample_value[31:0], include_req[32], zero pad
  input  logic         s_axis_tuser,   // kind
  input  logic         s_axis_tlast,   // last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [279:0] m_axis_tdata,   // included_count[10:0], status[12:11],
                                       // min[44:13], max[76:45], median[108:77],
                                       // lower_q[140:109], upper_q[172:141],
                                       // mean[204:173], upper_wsk[236:205],
                                       // lower_wsk[268:237], nearest[278:269], pad
  output logic         m_axis_tuser,   // result_kind
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i
);
  import bps_pkg::*;

  state_e state_q, state_d;

  logic [CNT_W-1:0]        n_q, arr_q, n_eff, arr_eff;
  logic signed [SUM_W-1:0] sum_q, sum_eff;
  logic                    done_q, ovf_q, ovf_eff, hinge_q, kind_q;
  logic signed [VAL_W-1:0] qv_q, in_val;
  logic                    in_acc, is_load, drop, ins;
  cell_ctrl_t              ctrl;

  logic signed [VAL_W-1:0] val_w [MAX_SAMPLES];
  logic [IDX_W-1:0]        pos_w [MAX_SAMPLES];
  logic                    gt_w  [MAX_SAMPLES];

  assign in_val  = $signed(s_axis_tdata[VAL_W-1:0]);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign is_load = (s_axis_tuser == KIND_LOAD);
  assign s_axis_tready = (state_q == S_IDLE);

  // A load after a summary starts a new set.
  assign n_eff   = done_q ? '0 : n_q;
  assign arr_eff = done_q ? '0 : arr_q;
  assign sum_eff = done_q ? '0 : sum_q;
  assign ovf_eff = done_q ? 1'b0 : ovf_q;
  assign drop    = (arr_eff >= CNT_W'(MAX_SAMPLES));
  assign ins     = in_acc && is_load && !drop && s_axis_tdata[VAL_W];

  assign ctrl.insert = ins;
  assign ctrl.rotate = (state_q == S_SCAN);

  // Sorted row of cells; cell 0 rotates back into the last cell's place.
  for (genvar gi = 0; gi < MAX_SAMPLES; gi++) begin : g_cell
    bps_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(gi)),
      .cnt_i      (n_eff),
      .ctrl_i     (ctrl),
      .new_val_i  (in_val),
      .new_pos_i  (arr_eff[IDX_W-1:0]),
      .left_val_i ((gi == 0) ? val_w[0] : val_w[(gi == 0) ? 0 : gi - 1]),
      .left_pos_i ((gi == 0) ? pos_w[0] : pos_w[(gi == 0) ? 0 : gi - 1]),
      .left_gt_i  ((gi == 0) ? 1'b0 : gt_w[(gi == 0) ? 0 : gi - 1]),
      .right_val_i(val_w[(gi + 1) % MAX_SAMPLES]),
      .right_pos_i(pos_w[(gi + 1) % MAX_SAMPLES]),
      .val_o      (val_w[gi]),
      .pos_o      (pos_w[gi]),
      .gt_o       (gt_w[gi])
    );
  end

  // Set bookkeeping and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q     <= '0;
      arr_q   <= '0;
      sum_q   <= '0;
      done_q  <= 1'b0;
      ovf_q   <= 1'b0;
      hinge_q <= 1'b0;
      kind_q  <= KIND_LOAD;
    end else begin
      if (cfg_we_i) begin
        hinge_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        kind_q <= s_axis_tuser;
        if (is_load) begin
          n_q    <= ins ? n_eff + 1'b1 : n_eff;
          arr_q  <= drop ? arr_eff : arr_eff + 1'b1;
          sum_q  <= ins ? sum_eff + SUM_W'(in_val) : sum_eff;
          ovf_q  <= ovf_eff || drop;
          done_q <= s_axis_tlast;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      qv_q <= in_val;
    end
  end

  // Mean divider starts as the scan starts.
  logic [IDX_W-1:0] scan_q;
  logic div_start;
  logic signed [VAL_W-1:0] mean_w;
  assign div_start = (state_q == S_SCAN) && (scan_q == '0);

  bps_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_q),
    .divisor_i (n_q),
    .mean_o    (mean_w)
  );

  // Ranks of the order statistics.
  logic [CNT_W+1:0] np1, i1_w, i3_w, c_w, ma_w, mb_w, last_w;
  always_comb begin
    np1    = (CNT_W+2)'(n_q) + 1'b1;
    c_w    = (CNT_W+2)'(scan_q);
    ma_w   = (CNT_W+2)'(n_q - 1'b1) >> 1;
    mb_w   = (CNT_W+2)'(n_q) >> 1;
    last_w = (CNT_W+2)'(n_q) - 1'b1;
    if (n_q >= CNT_W'(5)) begin
      i1_w = (np1 >> 2) - 1'b1;
      i3_w = (((np1 << 1) + np1) >> 2) - 1'b1;
    end else begin
      i1_w = '0;
      i3_w = last_w;
    end
  end

  // Scan capture of the values passing cell 0.
  logic signed [VAL_W-1:0] mn_q, mx_q, q1_q, q3_q, ma_q, mb_q, prev_q, cur_v;
  logic [IDX_W-1:0]        lastpos_q, cand_q, prevpos_q, cur_p;
  logic                    found_q, cur_ok, take_prev;
  logic signed [VAL_W:0]   d_lo, d_hi;

  assign cur_v  = val_w[0];
  assign cur_p  = pos_w[0];
  assign cur_ok = ({1'b0, scan_q} < n_q);
  assign d_lo   = (VAL_W+1)'(qv_q) - (VAL_W+1)'(prev_q);
  assign d_hi   = (VAL_W+1)'(cur_v) - (VAL_W+1)'(qv_q);
  assign take_prev = (scan_q != '0) && (cur_v != qv_q) && (d_lo < d_hi);

  // The search flag is kept until the result has been registered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= '0;
      found_q <= 1'b0;
    end else if (state_q == S_SCAN) begin
      scan_q <= scan_q + 1'b1;
      if (cur_ok && !found_q && (cur_v >= qv_q)) begin
        found_q <= 1'b1;
      end
    end else begin
      scan_q <= '0;
      if (state_q == S_IDLE) begin
        found_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN && cur_ok) begin
      if (scan_q == '0)   mn_q <= cur_v;
      if (c_w == last_w) begin
        mx_q      <= cur_v;
        lastpos_q <= cur_p;
      end
      if (c_w == i1_w)    q1_q <= cur_v;
      if (c_w == i3_w)    q3_q <= cur_v;
      if (c_w == ma_w)    ma_q <= cur_v;
      if (c_w == mb_w)    mb_q <= cur_v;
      if (!found_q && (cur_v >= qv_q)) begin
        cand_q <= take_prev ? prevpos_q : cur_p;
      end
      prev_q    <= cur_v;
      prevpos_q <= cur_p;
    end
  end

  // Final arithmetic: median and whiskers with saturation, nearest position.
  logic signed [WSK_W-1:0] q1x, q3x, iqr3, up_w, lw_w, medx;
  logic signed [VAL_W-1:0] up_s, lw_s, med_s;
  logic [IDX_W-1:0]        near_w;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [WSK_W-1:0] v);
    if (v > WSK_W'(signed'(32'sh7FFFFFFF))) begin
      return 32'sh7FFFFFFF;
    end else if (v < WSK_W'(signed'(-33'sh80000000))) begin
      return -32'sh80000000;
    end
    return v[VAL_W-1:0];
  endfunction

  always_comb begin
    q1x  = WSK_W'(q1_q);
    q3x  = WSK_W'(q3_q);
    iqr3 = ((q3x - q1x) <<< 1) + (q3x - q1x);
    medx = (WSK_W'(ma_q) + WSK_W'(mb_q)) >>> 1;
    if (n_q < CNT_W'(5)) begin
      up_w = WSK_W'(mx_q);
      lw_w = WSK_W'(mn_q);
    end else if (hinge_q) begin
      up_w = q3x + iqr3;
      lw_w = q1x - iqr3;
    end else begin
      up_w = ((q3x <<< 1) + iqr3) >>> 1;
      lw_w = ((q1x <<< 1) - iqr3) >>> 1;
    end
    up_s  = sat32(up_w);
    lw_s  = sat32(lw_w);
    med_s = sat32(medx);
    if (!found_q || (qv_q >= mx_q)) begin
      near_w = lastpos_q;
    end else begin
      near_w = cand_q;
    end
  end

  // Control sequence.
  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (!is_load || s_axis_tlast)) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_q == IDX_W'(MAX_SAMPLES - 1)) begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register.
  logic [1:0]   status_w;
  logic         empty_w;
  logic [279:0] tdata_d;
  assign empty_w  = (n_q == '0);
  assign status_w = ovf_q ? ST_OVERFLOW : (empty_w ? ST_EMPTY : ST_OK);

  // Result word assembled from the scan captures, the divider and the final arithmetic.
  always_comb begin
    tdata_d = '0;
    tdata_d[10:0]  = n_q;
    tdata_d[12:11] = status_w;
    if (!empty_w) begin
      if (kind_q == KIND_QUERY) begin
        tdata_d[278:269] = near_w;
      end else begin
        tdata_d[44:13]   = mn_q;
        tdata_d[76:45]   = mx_q;
        tdata_d[108:77]  = med_s;
        tdata_d[140:109] = q1_q;
        tdata_d[172:141] = q3_q;
        tdata_d[204:173] = mean_w;
        tdata_d[236:205] = up_s;
        tdata_d[268:237] = lw_s;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (state_q == S_CALC && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CALC && out_free) begin
      m_axis_tuser <= kind_q;
      m_axis_tdata <= tdata_d;
    end
  end

endmodule

>>> rtl/bps_checker.sv
// Port-level checks for the box plot summary engine, bound to the top level.
// Depends on bps_pkg and box_plot_summary_engine_top.
module bps_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [279:0] m_axis_tdata,
  input logic         m_axis_tuser
);
  import bps_pkg::*;

  // A result waiting for the sink stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A query transaction starts a scan, so input is refused next cycle.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_QUERY) |=> !s_axis_tready)
    else $error("input taken during scan");

  // Status is never the unused code.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[12:11] != 2'b11))
    else $error("bad status code");

  // An empty set never reports ok.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[10:0] == '0) |-> (m_axis_tdata[12:11] != ST_OK))
    else $error("empty set reported ok");

  // A summary carries no nearest position.
  a_summary_near: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[278:269] == '0))
    else $error("summary with nearest position");

endmodule

bind box_plot_summary_engine_top bps_checker u_bps_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
